FILE: design/ise_pkg.sv
// ----------------------------------------------------------------------------
// Insertion sort engine package
// Shared constants and item types for the sorting cell chain.
// ----------------------------------------------------------------------------
package ise_pkg;

   // Number of cells in the chain, which is the largest set kept in full.
   localparam int CAPACITY = 16;

   localparam int VALUE_WIDTH = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      value_type sample_value;
      logic      set_end;
   } req_type;

   typedef struct packed {
      value_type sorted_value;
      logic      run_end;
      logic      overflowed;
   } rsp_type;

   // Control that is broadcast from the top level to every cell.
   typedef struct packed {
      logic      do_insert;
      logic      do_shift;
      value_type sample;
   } cell_ctrl_type;

endpackage

FILE: design/ise_cell.sv
// ----------------------------------------------------------------------------
// Insertion sort cell
// Holds one stored value and takes part in insertion and output shifting.
// ----------------------------------------------------------------------------
module ise_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ise_pkg::cell_ctrl_type ctrl,
   input  logic                  left_valid,
   input  logic                  left_gt,
   input  ise_pkg::value_type    left_value,
   input  logic                  right_valid,
   input  ise_pkg::value_type    right_value,
   output logic                  own_valid,
   output logic                  own_gt,
   output ise_pkg::value_type    own_value
);
   import ise_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   value_type value_ff;
   value_type value_in;
   logic      gt;
   logic      take;

   // The chain is sorted, so the cells whose value exceeds the sample form a
   // contiguous tail. Those cells move one place right; the first free cell
   // opens up when no stored value is greater.
   assign gt   = valid_ff && (value_ff > ctrl.sample);
   assign take = gt || (!valid_ff && left_valid);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.do_shift) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctrl.do_insert && take) begin
         valid_in = 1'b1;
         value_in = left_gt ? left_value : ctrl.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign own_valid = valid_ff;
   assign own_gt    = gt;
   assign own_value = value_ff;

endmodule

FILE: design/insertion_sort_engine_core.sv
// ----------------------------------------------------------------------------
// Insertion sort engine core
// Sorts sets of signed values in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage: each item on the req_ channel carries one signed 32-bit value. While
// a set is being collected, one item is accepted in every cycle: all cells
// compare their value with the new sample at once and the larger ones move
// one place along the chain, so the sample lands after every equal value.
// The item marked set_end is inserted like the others and then switches the
// block to output. During output req_stall is high, and the chain shifts one
// place toward cell 0 for every item taken on the rsp_ channel; cell 0 is the
// output register. A set of n stored values therefore leaves as n items,
// starting the cycle after the set_end item was accepted, and the last one
// carries run_end. When the receiver stalls, the chain holds still and the
// presented item does not change. Values that arrive while all cells are
// full are dropped and every item of that set has overflowed set. After the
// final item is taken, the chain is empty and the next set may begin.
// Reset empties the chain and clears the overflow flag; there is no memory
// to sweep, so the block accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
module insertion_sort_engine_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ise_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ise_pkg::rsp_type rsp_item
);
   import ise_pkg::*;

   logic          draining_ff;
   logic          draining_in;
   logic          dropped_ff;
   logic          dropped_in;
   logic          req_accept;
   logic          rsp_accept;
   logic          chain_full;
   cell_ctrl_type ctrl;

   logic          cell_valid [CAPACITY];
   logic          cell_gt    [CAPACITY];
   value_type     cell_value [CAPACITY];

   // Input is refused only while a sorted set is leaving the chain.
   assign req_stall  = draining_ff;
   assign req_accept = req_valid && !draining_ff;
   assign rsp_valid  = draining_ff;
   assign rsp_accept = draining_ff && !rsp_stall;

   // The last cell holds a value exactly when the chain is full.
   assign chain_full = cell_valid[CAPACITY-1];

   assign ctrl.do_insert = req_accept && !chain_full;
   assign ctrl.do_shift  = rsp_accept;
   assign ctrl.sample    = req_item.sample_value;

   genvar k;
   generate
      for (k = 0; k < CAPACITY; k++) begin : g_cell
         logic      left_valid;
         logic      left_gt;
         value_type left_value;
         logic      right_valid;
         value_type right_value;

         if (k == 0) begin : g_head
            assign left_valid = 1'b1;
            assign left_gt    = 1'b0;
            assign left_value = '0;
         end else begin : g_body
            assign left_valid = cell_valid[k-1];
            assign left_gt    = cell_gt[k-1];
            assign left_value = cell_value[k-1];
         end

         if (k == CAPACITY - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_value = '0;
         end else begin : g_inner
            assign right_valid = cell_valid[k+1];
            assign right_value = cell_value[k+1];
         end

         ise_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_valid  (left_valid),
            .left_gt     (left_gt),
            .left_value  (left_value),
            .right_valid (right_valid),
            .right_value (right_value),
            .own_valid   (cell_valid[k]),
            .own_gt      (cell_gt[k]),
            .own_value   (cell_value[k])
         );
      end
   endgenerate

   // Output mode starts with the set_end item and ends when the item taken
   // is the last one held, which is when the second cell is empty.
   always_comb begin
      draining_in = draining_ff;
      dropped_in  = dropped_ff;
      if (req_accept) begin
         if (chain_full) begin
            dropped_in = 1'b1;
         end
         if (req_item.set_end) begin
            draining_in = 1'b1;
         end
      end
      if (rsp_accept && rsp_item.run_end) begin
         draining_in = 1'b0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         dropped_ff  <= dropped_in;
      end
   end

   assign rsp_item.sorted_value = cell_value[0];
   assign rsp_item.run_end      = !cell_valid[1];
   assign rsp_item.overflowed   = dropped_ff;

endmodule
